@@ src/itoa_pkg.sv @@
// Shared types, constants and helpers for the integer to ASCII formatter.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    // Width of the value field on the input port
    localparam int VALUE_FIELD_W = 32;
    localparam int DEFAULT_VALUE_WIDTH = 32;

    // Input bits consumed by one double-dabble stage
    localparam int BITS_PER_STAGE = 8;

    // Mode codes
    typedef enum logic [1:0] {
        MODE_SIGNED_DEC   = 2'd0,
        MODE_HEX          = 2'd1,
        MODE_UNSIGNED_DEC = 2'd2,
        MODE_SPARE        = 2'd3
    } mode_t;

    // ASCII codes
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [3:0] DIGIT_TEN   = 4'd10;

    typedef struct packed {
        logic [VALUE_FIELD_W-1:0] value_bits;
        logic [1:0]               opcode;
    } in_item_t;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       last_char;
    } out_item_t;

    // Per-item control flags that travel down the pipeline
    typedef struct packed {
        logic neg;
        logic hex;
    } flags_t;

    // Map one digit (0..15) to its lower-case ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + {4'd0, d};
        end
        else begin
            c = CHAR_LOWER_A + {4'd0, d - DIGIT_TEN};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/itoa_front.sv @@
// Entry stage: register the item, form the magnitude and the mode flags.
`timescale 1ns / 1ps
`default_nettype none

module itoa_front #(
    parameter int VALUE_WIDTH = itoa_pkg::DEFAULT_VALUE_WIDTH,
    parameter int PAD_W       = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   up_valid,
    output logic                        up_ready,
    input  wire itoa_pkg::in_item_t     up_item,
    output logic                        dn_valid,
    input  wire logic                   dn_ready,
    output logic [PAD_W-1:0]            dn_bits,
    output logic [VALUE_WIDTH-1:0]      dn_mag,
    output itoa_pkg::flags_t            dn_flags
);

    localparam int FW = itoa_pkg::VALUE_FIELD_W;

    logic                   valid_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    itoa_pkg::flags_t       flags_reg;
    logic [VALUE_WIDTH-1:0] v;
    logic [VALUE_WIDTH-1:0] mag_next;
    itoa_pkg::flags_t       flags_next;

    // Fit the value field to the working width
    if (VALUE_WIDTH >= FW) begin : g_widen
        assign v = VALUE_WIDTH'({{(VALUE_WIDTH + 1 - FW){1'b0}}, up_item.value_bits});
    end
    else begin : g_narrow
        assign v = up_item.value_bits[VALUE_WIDTH-1:0];
    end

    // Decode the mode and take the magnitude
    always_comb
    begin
        flags_next.neg = (up_item.opcode == itoa_pkg::MODE_SIGNED_DEC) && v[VALUE_WIDTH-1];
        flags_next.hex = (up_item.opcode == itoa_pkg::MODE_HEX);
        mag_next = flags_next.neg ? (~v + VALUE_WIDTH'(1)) : v;
    end

    assign up_ready = !valid_reg || dn_ready;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    // Capture payload on advance
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid) begin
            mag_reg   <= mag_next;
            flags_reg <= flags_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_mag   = mag_reg;
    assign dn_flags = flags_reg;
    assign dn_bits  = PAD_W'({{(PAD_W + 1 - VALUE_WIDTH){1'b0}}, mag_reg});

endmodule

`default_nettype wire

@@ src/itoa_dabble_stage.sv @@
// One double-dabble pipeline stage: shifts a byte of the magnitude into BCD.
`timescale 1ns / 1ps
`default_nettype none

module itoa_dabble_stage #(
    parameter int VALUE_WIDTH = itoa_pkg::DEFAULT_VALUE_WIDTH,
    parameter int PAD_W       = 32,
    parameter int BCD_W       = 40
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   up_valid,
    output logic                        up_ready,
    input  wire logic [PAD_W-1:0]       up_bits,
    input  wire logic [BCD_W-1:0]       up_bcd,
    input  wire logic [VALUE_WIDTH-1:0] up_mag,
    input  wire itoa_pkg::flags_t       up_flags,
    output logic                        dn_valid,
    input  wire logic                   dn_ready,
    output logic [PAD_W-1:0]            dn_bits,
    output logic [BCD_W-1:0]            dn_bcd,
    output logic [VALUE_WIDTH-1:0]      dn_mag,
    output itoa_pkg::flags_t            dn_flags
);

    localparam int STEPS  = itoa_pkg::BITS_PER_STAGE;
    localparam int DIGITS = BCD_W / 4;

    logic                   valid_reg;
    logic [PAD_W-1:0]       bits_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    itoa_pkg::flags_t       flags_reg;
    logic [PAD_W-1:0]       bits_next;
    logic [BCD_W-1:0]       bcd_next;

    // Run the add-3 and shift steps for this stage's bits
    always_comb
    begin
        bits_next = up_bits;
        bcd_next  = up_bcd;
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (bcd_next[d*4 +: 4] >= 4'd5) begin
                    bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
                end
            end
            bcd_next  = {bcd_next[BCD_W-2:0], bits_next[PAD_W-1]};
            bits_next = {bits_next[PAD_W-2:0], 1'b0};
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    // Capture payload on advance
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid) begin
            bits_reg  <= bits_next;
            bcd_reg   <= bcd_next;
            mag_reg   <= up_mag;
            flags_reg <= up_flags;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_bits  = bits_reg;
    assign dn_bcd   = bcd_reg;
    assign dn_mag   = mag_reg;
    assign dn_flags = flags_reg;

endmodule

`default_nettype wire

@@ src/itoa_serial.sv @@
// Output serializer: emits the sign and significant digits one per transaction.
`timescale 1ns / 1ps
`default_nettype none

module itoa_serial #(
    parameter int VALUE_WIDTH = itoa_pkg::DEFAULT_VALUE_WIDTH,
    parameter int BCD_W       = 40,
    parameter int NDIG        = 10,
    parameter int IDX_W       = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   up_valid,
    output logic                        up_ready,
    input  wire logic [BCD_W-1:0]       up_bcd,
    input  wire logic [VALUE_WIDTH-1:0] up_mag,
    input  wire itoa_pkg::flags_t       up_flags,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output itoa_pkg::out_item_t         out_data
);

    localparam int DW = NDIG * 4;

    logic             busy_reg;
    logic             minus_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [DW-1:0]    digits_reg;
    logic [DW-1:0]    digits_next;
    logic [IDX_W-1:0] top_next;
    logic             last_now;
    logic             advance;
    logic             load;

    // Pick hex nibbles or BCD digits and find the top significant digit
    always_comb
    begin
        if (up_flags.hex) begin
            digits_next = DW'({{(DW + 1 - VALUE_WIDTH){1'b0}}, up_mag});
        end
        else begin
            digits_next = DW'({{(DW + 1 - BCD_W){1'b0}}, up_bcd});
        end
        top_next = '0;
        for (int i = 1; i < NDIG; i++) begin
            if (digits_next[i*4 +: 4] != 4'd0) begin
                top_next = IDX_W'(i);
            end
        end
    end

    assign last_now = !minus_reg && (idx_reg == '0);
    assign advance  = busy_reg && out_ready;
    assign up_ready = !busy_reg || (out_ready && last_now);
    assign load     = up_valid && up_ready;

    // Advance the character position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            minus_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load) begin
            busy_reg  <= 1'b1;
            minus_reg <= up_flags.neg;
            idx_reg   <= top_next;
        end
        else if (advance) begin
            if (last_now) begin
                busy_reg <= 1'b0;
            end
            else if (minus_reg) begin
                minus_reg <= 1'b0;
            end
            else begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
        end
    end

    // Hold the digit string
    always_ff @(posedge clk)
    begin
        if (load) begin
            digits_reg <= digits_next;
        end
    end

    assign out_valid           = busy_reg;
    assign out_data.last_char  = last_now;
    assign out_data.ascii_char = minus_reg ? itoa_pkg::CHAR_MINUS
                                           : itoa_pkg::digit_char(digits_reg[idx_reg*4 +: 4]);

endmodule

`default_nettype wire

@@ src/integer_to_ascii_formatter_core.sv @@
// Top level of the integer to ASCII formatter.
//
//   channel  | signals                          | carries
//   ---------+----------------------------------+-------------------------------
//   input    | in_valid, in_ready, in_data      | value_bits, opcode
//   output   | out_valid, out_ready, out_data   | ascii_char, last_char
//
// An item passes the entry, double-dabble and serializer registers in turn; the
// serializer emits 1 to 11 characters per item at VALUE_WIDTH = 32 (sign plus up
// to 10 digits), one per output transaction. The double-dabble stages take a new
// item every cycle while downstream is ready, and stall in place. Reset (rst_n
// low) clears all valid bits; no payload state needs clearing.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter_core #(
    parameter int VALUE_WIDTH = itoa_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire itoa_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output itoa_pkg::out_item_t      out_data
);

    localparam int BPS        = itoa_pkg::BITS_PER_STAGE;
    localparam int NSTG       = (VALUE_WIDTH + BPS - 1) / BPS;
    localparam int PAD_W      = NSTG * BPS;
    localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int BCD_W      = DEC_DIGITS * 4;
    localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int IDX_W      = $clog2(NDIG);

    logic                   valid_s [0:NSTG];
    logic                   ready_s [0:NSTG];
    logic [PAD_W-1:0]       bits_s  [0:NSTG];
    logic [BCD_W-1:0]       bcd_s   [0:NSTG];
    logic [VALUE_WIDTH-1:0] mag_s   [0:NSTG];
    itoa_pkg::flags_t       flags_s [0:NSTG];

    // Register entry and form magnitude
    itoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .PAD_W       (PAD_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .up_item  (in_data),
        .dn_valid (valid_s[0]),
        .dn_ready (ready_s[0]),
        .dn_bits  (bits_s[0]),
        .dn_mag   (mag_s[0]),
        .dn_flags (flags_s[0])
    );
    assign bcd_s[0] = '0;

    // Binary to BCD conversion stages
    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        itoa_dabble_stage #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .PAD_W       (PAD_W),
            .BCD_W       (BCD_W)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_s[g]),
            .up_ready (ready_s[g]),
            .up_bits  (bits_s[g]),
            .up_bcd   (bcd_s[g]),
            .up_mag   (mag_s[g]),
            .up_flags (flags_s[g]),
            .dn_valid (valid_s[g+1]),
            .dn_ready (ready_s[g+1]),
            .dn_bits  (bits_s[g+1]),
            .dn_bcd   (bcd_s[g+1]),
            .dn_mag   (mag_s[g+1]),
            .dn_flags (flags_s[g+1])
        );
    end

    // Emit characters
    itoa_serial #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .BCD_W       (BCD_W),
        .NDIG        (NDIG),
        .IDX_W       (IDX_W)
    ) u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (valid_s[NSTG]),
        .up_ready  (ready_s[NSTG]),
        .up_bcd    (bcd_s[NSTG]),
        .up_mag    (mag_s[NSTG]),
        .up_flags  (flags_s[NSTG]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A minus sign never ends the text
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.ascii_char == itoa_pkg::CHAR_MINUS) |-> !out_data.last_char)
        else $error("minus sign marked as last character");

    // Text continues after a non-final character is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_char |=> out_valid)
        else $error("text ended without last character");

    // A minus sign is followed by a digit, never another minus
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (out_data.ascii_char == itoa_pkg::CHAR_MINUS)
        |=> out_data.ascii_char != itoa_pkg::CHAR_MINUS)
        else $error("repeated minus sign");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench for the integer to ASCII formatter: directed and random numbers, checked per character.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 145;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    itoa_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    itoa_pkg::out_item_t out_data;

    itoa_pkg::out_item_t expected_chars[$];
    int                  mismatch_count = 0;
    int                  idle_cycles = 0;
    int                  out_wait = 0;
    int                  out_gap = 0;
    bit                  stim_done = 1'b0;

    integer_to_ascii_formatter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    // Build the expected text of one number, most significant character first
    task automatic format_number(input logic [31:0] value_bits, input logic [1:0] opcode);
        logic [31:0]         mag;
        logic [31:0]         radix;
        logic [3:0]          digit;
        logic [7:0]          digits[$];
        itoa_pkg::out_item_t item;
        mag = value_bits;
        radix = 32'd10;
        if (itoa_pkg::mode_t'(opcode) == itoa_pkg::MODE_SIGNED_DEC && value_bits[31]) begin
            mag = ~value_bits + 32'd1;
            item.ascii_char = itoa_pkg::CHAR_MINUS;
            item.last_char = 1'b0;
            expected_chars.push_back(item);
        end
        else if (itoa_pkg::mode_t'(opcode) == itoa_pkg::MODE_HEX) begin
            radix = 32'd16;
        end
        do begin
            digit = 4'(mag % radix);
            digits.push_front(digit < 4'd10 ? itoa_pkg::CHAR_ZERO + 8'(digit)
                                            : itoa_pkg::CHAR_LOWER_A + 8'(digit - 4'd10));
            mag = mag / radix;
        end while (mag != 0);
        foreach (digits[i])
        begin
            item.ascii_char = digits[i];
            item.last_char = (i == digits.size() - 1);
            expected_chars.push_back(item);
        end
    endtask

    // Send one number after a random gap, then predict its text
    task automatic send_number(input logic [31:0] value_bits, input logic [1:0] opcode);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{value_bits: value_bits, opcode: opcode};
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        format_number(value_bits, opcode);
    endtask

    task automatic test_extremes();
        logic [31:0] vals[8];
        vals = '{32'h0, 32'h1, 32'h9, 32'ha, 32'h7fffffff, 32'h80000000,
                 32'hffffffff, 32'h80000001};
        for (int m = 0; m < 4; m++)
            foreach (vals[i])
                if (i < 6 || m == 0)
                    send_number(vals[i], 2'(m));
    endtask

    task automatic test_random();
        logic [31:0] v;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            v = $urandom();
            // Vary magnitude so short and long texts both appear
            if ($urandom_range(0, 2) == 0)
                v = v >> $urandom_range(0, 31);
            send_number(v, 2'($urandom_range(0, 3)));
        end
    endtask

    // Stall the receiving side for a random number of cycles before each character
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                out_gap = $urandom_range(0, 7);
                out_wait <= out_gap;
                out_ready <= (out_gap == 0);
            end
            else if (!out_ready) begin
                if (out_wait <= 1) begin
                    out_ready <= 1'b1;
                    out_wait <= 0;
                end
                else begin
                    out_wait <= out_wait - 1;
                end
            end
        end
    end

    // Compare each accepted character with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected character %h last %b", out_data.ascii_char,
                             out_data.last_char);
            end
            else begin
                if (out_data !== expected_chars[0]) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h/%b actual %h/%b",
                                 expected_chars[0].ascii_char, expected_chars[0].last_char,
                                 out_data.ascii_char, out_data.last_char);
                end
                void'(expected_chars.pop_front());
            end
        end
    end

    // End the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (stim_done && expected_chars.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_random();
        in_valid <= 1'b0;
        stim_done = 1'b1;
        wait (expected_chars.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
